@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the list engine RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("list engine assertion failed");

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("list engine forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/ple_pkg.sv @@
package ple_pkg;

    // Operation codes, equal to the func field of a command.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_e;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One command transfer.
    typedef struct packed {
        logic [1:0]         func;
        logic [4:0]         position;
        logic signed [31:0] value;
    } cmd_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [4:0]         length;
    } res_t;

    // Launch request from the command decoder to the sequencer.
    typedef struct packed {
        logic go;
        op_e  op;
    } seq_ctl_t;

    // Completion report from the sequencer.
    typedef struct packed {
        logic done;
        op_e  op;
    } seq_stat_t;

endpackage

@@ rtl/core/ple_ram.sv @@
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/ple_seq.sv @@
`include "assert_macros.svh"

module ple_seq #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ple_pkg::seq_ctl_t        ctl,
    input  logic [CNT_W-1:0]         idx,
    input  logic [CNT_W-1:0]         len,
    input  logic [ELEMENT_WIDTH-1:0] wdata_in,
    output ple_pkg::seq_stat_t       stat,
    output logic                     we,
    output logic [IDX_W-1:0]         waddr,
    output logic [ELEMENT_WIDTH-1:0] wdata,
    output logic [IDX_W-1:0]         raddr,
    input  logic [ELEMENT_WIDTH-1:0] rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STEP  = 4'b0010,
        S_MOVE  = 4'b0100,
        S_FETCH = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    ple_pkg::op_e             op_reg, op_next;
    logic [CNT_W-1:0]         cur_reg, cur_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [ELEMENT_WIDTH-1:0] val_reg, val_next;

    logic             is_insert;
    logic [CNT_W-1:0] nb;
    logic [CNT_W-1:0] cmp_a;
    logic [CNT_W-1:0] cmp_b;
    logic             more;

    // Shared index unit: one adder steps the cursor, one comparator ends the walk.
    // Insert walks down from the old length, remove walks up from the position.
    assign is_insert = (op_reg == ple_pkg::OP_INSERT);
    assign nb        = is_insert ? (cur_reg - CNT_W'(1)) : (cur_reg + CNT_W'(1));
    assign cmp_a     = is_insert ? cur_reg : len_reg;
    assign cmp_b     = is_insert ? idx_reg : nb;
    assign more      = (cmp_a > cmp_b);

    // Sequencer: each moved entry is read at the neighbor and written at the cursor.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        we         = 1'b0;
        waddr      = cur_reg[IDX_W-1:0];
        wdata      = rdata;
        raddr      = (op_reg == ple_pkg::OP_READ) ? cur_reg[IDX_W-1:0] : nb[IDX_W-1:0];
        stat.done  = 1'b0;
        stat.op    = op_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.go)
                begin
                    op_next    = ctl.op;
                    idx_next   = idx;
                    len_next   = len;
                    val_next   = wdata_in;
                    cur_next   = (ctl.op == ple_pkg::OP_INSERT) ? len : idx;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (op_reg == ple_pkg::OP_READ)
                begin
                    state_next = S_FETCH;
                end
                else if (more)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    // The walk is over; an insert drops the new value in place.
                    we         = is_insert;
                    wdata      = val_reg;
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                we         = 1'b1;
                cur_next   = nb;
                state_next = S_STEP;
            end
            S_FETCH:
            begin
                stat.done  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ple_pkg::OP_READ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Operands of the running operation.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        len_reg <= len_next;
        val_reg <= val_next;
    end

    `ASSERT_CLK(a_go_when_idle, clk, rst_n, ctl.go |-> state_reg == S_IDLE)
    `ASSERT_CLK(a_move_then_step, clk, rst_n, state_reg == S_MOVE |=> state_reg == S_STEP)
    `ASSERT_NEVER(a_insert_write_in_list, clk, rst_n, we && is_insert && (cur_reg > len_reg))

endmodule

@@ rtl/core/positional_list_engine_unit.sv @@
// Positional list engine: an ordered list of up to CAPACITY signed entries in a
// single-port-pair RAM, addressed by 1-based position. A command is taken when
// start is high and busy is low; its one result appears for a single cycle with
// strobe high and must be taken then, as the receiver cannot stall. A command
// that fails its checks (bad position, empty or full list, unused code) leaves
// busy low and gives its result in the next cycle, so such commands may follow
// each other every cycle. Work on the list is done by one sequencer with one
// index adder and comparator that moves entries one at a time through the
// RAM; the result strobe rises in the same cycle as busy falls.
`include "assert_macros.svh"

module positional_list_engine_unit #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ple_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            strobe,
    output ple_pkg::res_t   result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    logic                     busy_reg, busy_next;
    logic                     strobe_reg, strobe_next;
    logic [CNT_W-1:0]         length_reg, length_next;
    ple_pkg::res_t            result_reg, result_next;

    logic                     accept;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         len_w;
    logic [CMP_W-1:0]         pos_m1;
    logic [CMP_W-1:0]         len_after;
    logic                     dec_ok;
    logic [1:0]               dec_status;
    logic [63:0]              value_ext;
    logic [63:0]              elem_ext;

    ple_pkg::seq_ctl_t        ctl;
    ple_pkg::seq_stat_t       stat;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    assign accept = start && !busy_reg;
    assign pos_w  = CMP_W'(cmd.position);
    assign len_w  = CMP_W'(length_reg);
    assign pos_m1 = pos_w - CMP_W'(1);

    // Command checks against the current length.
    always_comb
    begin
        dec_ok     = 1'b0;
        dec_status = ple_pkg::ST_RANGE;
        unique case (cmd.func)
            ple_pkg::OP_INSERT:
            begin
                priority if ((pos_w == '0) || (pos_w > (len_w + CMP_W'(1))))
                    dec_status = ple_pkg::ST_RANGE;
                else if (len_w >= CMP_W'(CAPACITY))
                    dec_status = ple_pkg::ST_FULL;
                else
                    dec_ok = 1'b1;
            end
            ple_pkg::OP_REMOVE:
            begin
                priority if (len_w == '0)
                    dec_status = ple_pkg::ST_EMPTY;
                else if ((pos_w == '0) || (pos_w > len_w))
                    dec_status = ple_pkg::ST_RANGE;
                else
                    dec_ok = 1'b1;
            end
            ple_pkg::OP_READ:
            begin
                priority if ((pos_w == '0) || (pos_w > len_w))
                    dec_status = ple_pkg::ST_RANGE;
                else
                    dec_ok = 1'b1;
            end
            default:
            begin
                dec_status = ple_pkg::ST_RANGE;
            end
        endcase
    end

    // Launch the sequencer for a command that passed its checks.
    assign ctl.go    = accept && dec_ok;
    assign ctl.op    = ple_pkg::op_e'(cmd.func);
    assign value_ext = {32'b0, cmd.value};

    // Stored entries are sign-extended from the element width on the way out.
    assign elem_ext = 64'($signed(ram_rdata));

    // Length after a finished operation.
    always_comb
    begin
        unique case (stat.op)
            ple_pkg::OP_INSERT: len_after = len_w + CMP_W'(1);
            ple_pkg::OP_REMOVE: len_after = len_w - CMP_W'(1);
            default:            len_after = len_w;
        endcase
    end

    // Result register and length bookkeeping.
    always_comb
    begin
        busy_next   = busy_reg;
        length_next = length_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        if (stat.done)
        begin
            busy_next           = 1'b0;
            length_next         = len_after[CNT_W-1:0];
            strobe_next         = 1'b1;
            result_next.status  = ple_pkg::ST_OK;
            result_next.element = (stat.op == ple_pkg::OP_READ) ? elem_ext[31:0] : 32'sd0;
            result_next.length  = len_after[4:0];
        end
        else if (accept)
        begin
            if (dec_ok)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                strobe_next         = 1'b1;
                result_next.status  = dec_status;
                result_next.element = 32'sd0;
                result_next.length  = len_w[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            length_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            strobe_reg <= strobe_next;
            length_reg <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Entry storage.
    ple_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shift and fetch sequencer.
    ple_seq #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (pos_m1[CNT_W-1:0]),
        .len      (length_reg),
        .wdata_in (value_ext[ELEMENT_WIDTH-1:0]),
        .stat     (stat),
        .we       (ram_we),
        .waddr    (ram_waddr),
        .wdata    (ram_wdata),
        .raddr    (ram_raddr),
        .rdata    (ram_rdata)
    );

    `ASSERT_CLK(a_done_only_busy, clk, rst_n, stat.done |-> busy_reg)
    `ASSERT_CLK(a_strobe_not_busy, clk, rst_n, strobe_reg |-> !busy_reg)
    `ASSERT_NEVER(a_length_bound, clk, rst_n, CMP_W'(length_reg) > CMP_W'(CAPACITY))

endmodule

@@ dv/tb_positional_list_engine_unit.sv @@
module tb_positional_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_CAPACITY = 16;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          SEGMENT_ITEMS = 40;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    ple_pkg::cmd_t  cmd;
    logic           busy;
    logic           strobe;
    ple_pkg::res_t  result;

    // Shadow copy of the list contents and its entry count.
    logic signed [31:0] shadow_list [LIST_CAPACITY];
    int                 shadow_len;

    // Results predicted for accepted commands, oldest first.
    ple_pkg::res_t awaited_results [$];

    int error_count;
    int cycle_count;
    int sent_count;
    int ok_count;
    int range_count;
    int empty_count;
    int full_count;
    int times_full;

    positional_list_engine_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always #2 clk = ~clk;

    // Abort the run if it never reaches its normal end.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Apply one command to the shadow list and return the result it must give.
    function automatic ple_pkg::res_t list_apply(ple_pkg::cmd_t c);
        ple_pkg::res_t r;
        int            pos;
        int            i;
        pos       = int'(c.position);
        r.status  = ple_pkg::ST_RANGE;
        r.element = '0;
        case (c.func)
            ple_pkg::OP_INSERT:
            begin
                if (pos == 0 || pos > shadow_len + 1)
                    r.status = ple_pkg::ST_RANGE;
                else if (shadow_len >= LIST_CAPACITY)
                    r.status = ple_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_len; i >= pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos - 1] = c.value;
                    shadow_len++;
                    r.status = ple_pkg::ST_OK;
                end
            end
            ple_pkg::OP_REMOVE:
            begin
                if (shadow_len == 0)
                    r.status = ple_pkg::ST_EMPTY;
                else if (pos == 0 || pos > shadow_len)
                    r.status = ple_pkg::ST_RANGE;
                else
                begin
                    for (i = pos; i < shadow_len; i++)
                        shadow_list[i - 1] = shadow_list[i];
                    shadow_len--;
                    r.status = ple_pkg::ST_OK;
                end
            end
            ple_pkg::OP_READ:
            begin
                if (pos == 0 || pos > shadow_len)
                    r.status = ple_pkg::ST_RANGE;
                else
                begin
                    r.element = shadow_list[pos - 1];
                    r.status  = ple_pkg::ST_OK;
                end
            end
            default:
                r.status = ple_pkg::ST_RANGE;
        endcase
        r.length = shadow_len[4:0];
        return r;
    endfunction

    function automatic ple_pkg::cmd_t cmd_of(logic [1:0] f, logic [4:0] p,
                                             logic signed [31:0] v);
        ple_pkg::cmd_t c;
        c.func     = f;
        c.position = p;
        c.value    = v;
        return c;
    endfunction

    // Values lean toward the extremes so that sign and edge bits are exercised.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed commands for the current length, with some noise mixed in.
    function automatic ple_pkg::cmd_t pick_cmd(int insert_pct);
        ple_pkg::cmd_t c;
        int            roll;
        c.value = pick_value();
        if ($urandom_range(99) < 8)
        begin
            c.func     = 2'($urandom_range(3));
            c.position = 5'($urandom_range(31));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                c.func = ple_pkg::OP_INSERT;
            else if (roll < insert_pct + (100 - insert_pct) / 2)
                c.func = ple_pkg::OP_REMOVE;
            else
                c.func = ple_pkg::OP_READ;
            if (c.func == ple_pkg::OP_INSERT)
                c.position = 5'($urandom_range(shadow_len + 1, 1));
            else if (shadow_len == 0)
                c.position = 5'($urandom_range(31));
            else
                c.position = 5'($urandom_range(shadow_len, 1));
        end
        return c;
    endfunction

    // Hold start low for a random number of cycles before the next command.
    task automatic sender_pause(int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Present one command and wait for its transfer; start stays high afterward.
    task automatic send_cmd(ple_pkg::cmd_t c);
        ple_pkg::res_t want;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        want = list_apply(c);
        awaited_results.push_back(want);
        sent_count++;
        case (want.status)
            ple_pkg::ST_OK:    ok_count++;
            ple_pkg::ST_RANGE: range_count++;
            ple_pkg::ST_EMPTY: empty_count++;
            default:           full_count++;
        endcase
        if (c.func == ple_pkg::OP_INSERT && want.status == ple_pkg::ST_OK &&
            shadow_len == LIST_CAPACITY)
            times_full++;
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        ple_pkg::res_t want;
        if (rst_n && strobe)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result transfer with no command outstanding");
            else
            begin
                want = awaited_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.element !== want.element)
                    report_mismatch($sformatf("element got %0h want %0h",
                                              result.element, want.element));
                if (result.length !== want.length)
                    report_mismatch($sformatf("length got %0d want %0d",
                                              result.length, want.length));
            end
        end
    end

    // Empty-list errors, bad positions, the unused code and inserts at each end.
    task automatic test_directed();
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd0,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd31, 32'sd0));
        send_cmd(cmd_of(FUNC_UNUSED,        5'd1,  32'sd5));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd0,  32'sd9));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd2,  32'sd9));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd1,  32'sh7fffffff));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd2,  32'sh80000000));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd2,  -32'sd1));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd31, 32'sd3));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd0,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd2,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd4,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd5,  32'sd0));
        send_cmd(cmd_of(FUNC_UNUSED,        5'd31, -32'sd1));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd0,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd5,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd2,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd3,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd1,  32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'd1,  32'sd0));
    endtask

    // Fill the list to capacity, push against the limit, then drain it.
    task automatic test_fill_and_drain(int idle_pct);
        while (shadow_len < LIST_CAPACITY)
        begin
            sender_pause(idle_pct);
            send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'($urandom_range(shadow_len + 1, 1)),
                            pick_value()));
        end
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd1,  pick_value()));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd17, pick_value()));
        send_cmd(cmd_of(ple_pkg::OP_INSERT, 5'd18, pick_value()));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd16, 32'sd0));
        send_cmd(cmd_of(ple_pkg::OP_READ,   5'd17, 32'sd0));
        while (shadow_len > 0)
        begin
            sender_pause(idle_pct);
            send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'($urandom_range(shadow_len, 1)),
                            pick_value()));
        end
        send_cmd(cmd_of(ple_pkg::OP_REMOVE, 5'($urandom_range(31)), pick_value()));
    endtask

    // Random traffic in segments that alternately grow and shrink the list.
    task automatic test_random_traffic(int count, int idle_pct);
        int insert_pct;
        for (int n = 0; n < count; n++)
        begin
            insert_pct = ((n / SEGMENT_ITEMS) % 2 == 0) ? 80 : 20;
            sender_pause(idle_pct);
            send_cmd(pick_cmd(insert_pct));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        shadow_len = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain(7);
        test_random_traffic(280, 7);
        test_random_traffic(280, 71);
        test_random_traffic(280, 0);

        // Stop sending and let the last results arrive.
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d succeeded, %0d out of range, %0d on an empty list,",
                 sent_count, ok_count, range_count, empty_count);
        $display("%0d inserts into a full list; the list reached capacity %0d times.",
                 full_count, times_full);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/ple_seq.sv
rtl/core/positional_list_engine_unit.sv
dv/tb_positional_list_engine_unit.sv
